// File: hw/rtl/isu_pkg.sv
// shared constants and types for the insertion sorter
`timescale 1ns / 1ps

package isu_pkg;

    localparam int MAX_LEN = 16;
    localparam int DATA_W  = 32;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     shift;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // what a cell shows to its neighbours
    typedef struct packed {
        logic                     valid;
        logic                     ge;
        logic signed [DATA_W-1:0] value;
    } t_cell;

endpackage

// File: hw/rtl/isu_cell.sv
// one sorting cell: holds a single stored value and its valid bit
`timescale 1ns / 1ps

module isu_cell
    import isu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_cell i_lower,
    input  t_cell i_upper,
    output t_cell o_cell
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_value;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_value;
    logic                     ge;

    // this cell moves up for the new value: empty, or strictly greater
    assign ge = !r_valid || (r_value > i_cmd.value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        priority if (i_cmd.shift) begin
            n_valid = i_upper.valid;
            n_value = i_upper.value;
        end else if (i_cmd.ins) begin
            priority if (i_lower.ge) begin
                n_valid = i_lower.valid;
                n_value = i_lower.value;
            end else if (ge) begin
                n_valid = 1'b1;
                n_value = i_cmd.value;
            end else begin
                n_valid = r_valid;
                n_value = r_value;
            end
        end else begin
            n_valid = r_valid;
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.ge    = ge;
    assign o_cell.value = r_value;

endmodule

// File: hw/rtl/insertion_sorter_unit.sv
// top level of the insertion sorter: cell chain, drain control and output register
//
// Usage
//   Input channel (i_valid / o_stall): one signed value per transaction,
//   i_final_req high on the last value of a list. While loading, one value is
//   taken every cycle; each is inserted into the cell chain in that cycle,
//   equal values keeping their arrival order. Up to MAX_LEN values are kept;
//   later ones are dropped and o_overflow is raised on that list's results.
//   Output channel (o_valid / i_stall): after the final value is taken, the
//   chain shifts towards cell 0 and, while the receiver does not stall, emits
//   one stored value per cycle in ascending order, o_end_of_list on the last
//   one. Each result passes from cell 0 into the output register. o_stall is
//   high for the whole drain, so the next list starts at the earliest in the
//   cycle after the last result was loaded.
//   A stall from the receiver holds the output register and halts the drain.
//   Reset empties the chain, clears the overflow mark and the output valid.
`timescale 1ns / 1ps

module insertion_sorter_unit
    import isu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_final_req,
    output logic                     o_stall,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_end_of_list,
    output logic                     o_overflow,
    input  logic                     i_stall
);

    t_cmd  cmd;
    t_cell cells [MAX_LEN];

    logic r_draining;
    logic r_drop;
    logic r_o_valid;
    logic signed [DATA_W-1:0] r_o_value;
    logic r_o_end;
    logic r_o_ovf;

    logic accept_in;
    logic full;
    logic emit;
    logic last;

    assign accept_in = i_valid && !r_draining;
    assign full      = cells[MAX_LEN-1].valid;
    assign emit      = r_draining && (!r_o_valid || !i_stall);

    assign cmd.ins   = accept_in && !full;
    assign cmd.shift = emit;
    assign cmd.value = i_value;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
            t_cell lower;
            t_cell upper;
            if (gi == 0) begin : g_first
                assign lower = '0;
            end else begin : g_mid
                assign lower = cells[gi-1];
            end
            if (gi == MAX_LEN - 1) begin : g_top
                assign upper = '0;
            end else begin : g_below
                assign upper = cells[gi+1];
            end
            isu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_lower (lower),
                .i_upper (upper),
                .o_cell  (cells[gi])
            );
        end
        if (MAX_LEN == 1) begin : g_one
            assign last = 1'b1;
        end else begin : g_many
            assign last = !cells[1].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_drop     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept_in && full) begin
                r_drop <= 1'b1;
            end
            if (accept_in && i_final_req) begin
                r_draining <= 1'b1;
            end
            if (emit && last) begin
                r_draining <= 1'b0;
                r_drop     <= 1'b0;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_o_value <= cells[0].value;
            r_o_end   <= last;
            r_o_ovf   <= r_drop;
        end
    end

    assign o_stall        = r_draining;
    assign o_valid        = r_o_valid;
    assign o_sorted_value = r_o_value;
    assign o_end_of_list  = r_o_end;
    assign o_overflow     = r_o_ovf;

endmodule

// File: bench/tb_top.sv
// testbench for the insertion sorter: stable sorting of signed lists, overflow and end marks
`timescale 1ns / 1ps

module tb_top;
    import isu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_list;
        logic                     overflow;
    } t_sorted_entry;

    typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE} t_value_mix;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     i_final_req = 1'b0;
    logic                     i_stall     = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_end_of_list;
    logic                     o_overflow;

    // predictor copy of the list being built
    logic signed [DATA_W-1:0] list_store [MAX_LEN];
    int                       list_count   = 0;
    logic                     list_dropped = 1'b0;
    t_sorted_entry            pending_sorted_q [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    insertion_sorter_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_value        (i_value),
        .i_final_req    (i_final_req),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_end_of_list  (o_end_of_list),
        .o_overflow     (o_overflow),
        .i_stall        (i_stall)
    );

    always #10 i_clk = ~i_clk;

    // stable insertion; a final value empties the list into the expected queue
    function automatic void insert_and_drain(input logic signed [DATA_W-1:0] v,
                                             input logic fin);
        int            pos;
        t_sorted_entry entry;
        if (list_count >= MAX_LEN) begin
            list_dropped = 1'b1;
        end else begin
            pos = list_count;
            while (pos > 0 && list_store[pos-1] > v) begin
                list_store[pos] = list_store[pos-1];
                pos--;
            end
            list_store[pos] = v;
            list_count++;
        end
        if (fin) begin
            for (int k = 0; k < list_count; k++) begin
                entry.value       = list_store[k];
                entry.end_of_list = (k == list_count - 1);
                entry.overflow    = list_dropped;
                pending_sorted_q.push_back(entry);
            end
            list_count   = 0;
            list_dropped = 1'b0;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value(input t_value_mix mix);
        logic signed [DATA_W-1:0] v;
        case (mix)
            VAL_NARROW: v = $signed($urandom_range(8)) - 4;
            VAL_EDGE: begin
                case ($urandom_range(4))
                    0:       v = {1'b1, {(DATA_W-1){1'b0}}};
                    1:       v = {1'b0, {(DATA_W-1){1'b1}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_value     <= v;
        i_final_req <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        insert_and_drain(v, fin);
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sorted_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_single_value;
        send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
    endtask

    task automatic test_extremes;
        send_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
    endtask

    task automatic test_equal_values;
        send_item(32'sd5, 1'b0);
        send_item(-32'sd3, 1'b0);
        send_item(32'sd5, 1'b1);
    endtask

    // seventeen values: the final one is dropped and still closes the list
    task automatic test_overflow;
        for (int k = 0; k < MAX_LEN + 1; k++)
            send_item(rand_value(VAL_WIDE), k == MAX_LEN);
        wait_drained();
    endtask

    task automatic test_random_lists(input int n_items);
        int         sent;
        int         len;
        t_value_mix mix;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1:    len = $urandom_range(MAX_LEN + 6, MAX_LEN + 1);
                2:       len = MAX_LEN;
                default: len = $urandom_range(MAX_LEN, 1);
            endcase
            mix = t_value_mix'($urandom_range(2));
            for (int k = 0; k < len; k++)
                send_item(rand_value(mix), k == len - 1);
            sent += len;
            if ($urandom_range(9) == 0)
                wait_drained();
        end
    endtask

    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge i_clk) begin : check_results
        t_sorted_entry exp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sorted_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: value %0d eol %0b ovf %0b",
                             o_sorted_value, o_end_of_list, o_overflow);
            end else begin
                exp = pending_sorted_q.pop_front();
                if (o_sorted_value !== exp.value || o_end_of_list !== exp.end_of_list ||
                    o_overflow !== exp.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 exp.value, exp.end_of_list, exp.overflow,
                                 o_sorted_value, o_end_of_list, o_overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 69;
        test_single_value();
        test_extremes();
        test_equal_values();
        test_overflow();
        test_random_lists(84);

        send_idle_pct = 69;
        recv_idle_pct = 21;
        test_random_lists(83);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lists(83);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_sorted_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
